FILE: rtl/bcet_pkg.sv
// Package for the battery current and ETA unit: shared types, register
// indexes, divider control structs and fixed scale constants.
// No dependencies.
package bcet_pkg;

  // Shared divider geometry
  localparam int DIV_W    = 49;   // dividend / quotient width
  localparam int DVSR_W   = 32;   // divisor / remainder width
  localparam int CNT_W    = 6;    // iteration counter width
  localparam logic [CNT_W-1:0] ITER_X4  = 6'd49;  // current scaling pass
  localparam logic [CNT_W-1:0] ITER_MIN = 6'd26;  // minutes pass

  // Scaling constants
  localparam logic [14:0] NUM_SCALE   = 15'd20000;
  localparam logic [11:0] DEN_SCALE   = 12'd2147;
  localparam logic [37:0] DEADBAND_X4 = 38'd2000;    // 500 mA x4
  localparam logic [38:0] REP_HALF    = 39'd200;     // half of 400 (x4 per 100 mA)
  localparam logic [38:0] REP_SAT     = 39'd26214400; // 65536 * 400
  localparam logic [31:0] DIR_THRESH  = 32'd200;
  localparam logic [9:0]  MIN_FACTOR  = 10'd600;
  localparam logic [15:0] MINUTES_CAP = 16'hFFFE;
  localparam logic [15:0] UNKNOWN_MIN = 16'hFFFF;
  localparam logic [6:0]  PCT_FACTOR  = 7'd93;
  localparam logic [6:0]  SOC_FULL    = 7'd100;

  // Reciprocals: floor(y/25) = (y*REC25) >> 26, floor(p/100) = (p*REC100) >> 30
  localparam logic [21:0] REC25  = 22'd2684355;
  localparam logic [23:0] REC100 = 24'd10737419;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SENSE_RES_VALUE   = 3'd0,
    CFG_SENSE_RES_SCALE   = 3'd1,
    CFG_DEFAULT_RES_VALUE = 3'd2,
    CFG_DEFAULT_RES_SCALE = 3'd3,
    CFG_ZERO_OFFSET_X4    = 3'd4,
    CFG_ZERO_VALID        = 3'd5
  } cfg_idx_t;

  // Current direction
  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_CHG  = 2'd1,
    DIR_DSG  = 2'd2
  } dir_t;

  // Divider request and status
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/bcet_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bcet_pkg for widths and the control/status structs.
module bcet_div import bcet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [DIV_W-1:0]  dividend,  // left-justified for the chosen iteration count
  input  logic [DVSR_W-1:0] divisor,
  output div_sts_t          sts,
  output logic [DIV_W-1:0]  quotient
);

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              ge;

  // One step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = ctl.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/battery_current_and_eta_unit.sv
// Top level of the battery current and ETA unit: sequencer, config registers,
// moving average and output register. Depends on bcet_pkg and bcet_div.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in_     | slave     | in_tvalid/in_tready | in_tdata (56b), in_tuser (1b)
//  out_    | master    | out_tvalid/tready   | out_tdata (112b)
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (19b)
//
// A word passes from accept to the output register through two passes of the
// shared bit-serial divider (49 quotient bits for the current scaling, 26
// for the minutes estimate, each ending on its registered done flag) and eight
// sequencer steps; paths with no minutes divide (idle current or unknown SOC)
// skip the second pass. The next word is accepted in the cycle after the load.
// rst_n is synchronous; it resets the sequencer, the average and the config registers.
// A result waits in the output register while the next word is processed;
// the sequencer stalls only if a new result is ready before the old one is taken.
module battery_current_and_eta_unit import bcet_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  // input words
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [55:0]   in_tdata,   // adc_word[15:0], capacity_full[31:16],
                                    // capacity_now[47:32], soc_percent[54:48]
  input  logic          in_tuser,   // soc_known
  // result words
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // signed_ma[31:0], charge_report[47:32],
                                    // discharge_report[63:48], minutes_real[79:64],
                                    // minutes_to_full[95:80], minutes_to_empty[111:96]
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [18:0]   cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_PREP  = 11'b000_0000_0010,
    ST_MUL   = 11'b000_0000_0100,
    ST_DIV1  = 11'b000_0000_1000,
    ST_CUR   = 11'b000_0001_0000,
    ST_EMA   = 11'b000_0010_0000,
    ST_MIN   = 11'b000_0100_0000,
    ST_DIV2  = 11'b000_1000_0000,
    ST_SCALE = 11'b001_0000_0000,
    ST_PCT   = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  // Control registers
  state_t       state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  ema_r, ema_nxt;
  dir_t         ema_dir_r, ema_dir_nxt;

  // Config registers
  logic [15:0]  sense_res_value_r, sense_res_value_nxt;
  logic [15:0]  sense_res_scale_r, sense_res_scale_nxt;
  logic [15:0]  default_res_value_r, default_res_value_nxt;
  logic [15:0]  default_res_scale_r, default_res_scale_nxt;
  logic [18:0]  zero_offset_r, zero_offset_nxt;
  logic         zero_valid_r, zero_valid_nxt;

  // Payload registers
  logic [15:0]  adc_r, adc_nxt;
  logic         soc_known_r, soc_known_nxt;
  logic [15:0]  cfull_r, cfull_nxt;
  logic [15:0]  cnow_r, cnow_nxt;
  logic [6:0]   soc_r, soc_nxt;
  logic         corr_neg_r, corr_neg_nxt;
  logic [18:0]  mag_r, mag_nxt;
  logic         scale_ok_r, scale_ok_nxt;
  logic [30:0]  ns_r, ns_nxt;
  logic [27:0]  den_r, den_nxt;
  logic [37:0]  x4_r, x4_nxt;
  logic         chg_r, chg_nxt;
  logic         nz_r, nz_nxt;
  logic [31:0]  cur_ma_r, cur_ma_nxt;
  logic [31:0]  curmag_r, curmag_nxt;
  dir_t         dir_r, dir_nxt;
  logic [20:0]  rep_y_r, rep_y_nxt;
  logic         rep_sat_r, rep_sat_nxt;
  logic [15:0]  chg_rep_r, chg_rep_nxt;
  logic [15:0]  dsg_rep_r, dsg_rep_nxt;
  logic [25:0]  capx_r, capx_nxt;
  logic [15:0]  m_r, m_nxt;
  logic [22:0]  p93_r, p93_nxt;
  logic [15:0]  real_r, real_nxt;
  logic [15:0]  tfull_r, tfull_nxt;
  logic [15:0]  tempty_r, tempty_nxt;
  logic [111:0] out_data_r, out_data_nxt;

  // Divider hookup
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic [DIV_W-1:0]  div_q;

  // Combinational helpers
  logic [15:0]  sw;
  logic [19:0]  corr_c;
  logic [19:0]  corr_abs;
  logic [15:0]  res_sel, num_sel;
  logic [48:0]  scaled_c;
  logic [37:0]  x4_c;
  logic [38:0]  ma_sum;
  logic [36:0]  ma_c;
  logic [31:0]  mag32_c;
  logic [38:0]  rep_sum;
  logic [42:0]  rep_prod;
  logic [15:0]  rep_c;
  logic [36:0]  ema_sum;
  logic [15:0]  cap_c;
  logic [46:0]  pct_prod;
  logic [15:0]  pct_c;
  logic         load_out;

  bcet_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Offset-corrected count x4, magnitude and resistance choice
  assign sw       = {adc_r[7:0], adc_r[15:8]};
  assign corr_c   = {{2{sw[15]}}, sw, 2'b00}
                  - (zero_valid_r ? {zero_offset_r[18], zero_offset_r} : 20'd0);
  assign corr_abs = corr_c[19] ? (~corr_c + 20'd1) : corr_c;
  assign res_sel  = (sense_res_value_r != 16'd0) ? sense_res_value_r : default_res_value_r;
  assign num_sel  = (sense_res_scale_r != 16'd0) ? sense_res_scale_r : default_res_scale_r;

  // Numerator for the scaling divide, rounded half up
  assign scaled_c = 49'(mag_r) * 49'(ns_r) + 49'(den_r >> 1);

  // Scaled current with deadband
  always_comb begin
    x4_c = scale_ok_r ? div_q[37:0] : 38'd0;
    if (!zero_valid_r && (x4_c < DEADBAND_X4)) begin
      x4_c = 38'd0;
    end
  end

  // Rounded mA, saturated by direction
  assign ma_sum = {1'b0, x4_r} + 39'd2;
  assign ma_c   = ma_sum[38:2];
  always_comb begin
    if (!corr_neg_r) begin
      mag32_c = (ma_c > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : ma_c[31:0];
    end else begin
      mag32_c = (ma_c > 37'h0_8000_0000) ? 32'h8000_0000 : ma_c[31:0];
    end
  end

  // Report in 100 mA units: (x4 + 200) / 400 as >>4 then reciprocal of 25
  assign rep_sum  = {1'b0, x4_r} + REP_HALF;
  assign rep_prod = 43'(rep_y_r) * 43'(REC25);
  assign rep_c    = rep_sat_r ? 16'hFFFF : rep_prod[41:26];

  // Moving average step: (15*ema + cur + 8) / 16
  assign ema_sum = ({5'd0, ema_r} << 4) - {5'd0, ema_r} + {5'd0, curmag_r} + 37'd8;

  // Capacity left to move in the current direction
  assign cap_c = (dir_r == DIR_CHG) ? ((cfull_r >= cnow_r) ? (cfull_r - cnow_r) : 16'd0)
                                    : cnow_r;

  // 93 percent: floor(p / 100) by reciprocal
  assign pct_prod = 47'(p93_r) * 47'(REC100);
  assign pct_c    = pct_prod[45:30];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ema_nxt       = ema_r;
    ema_dir_nxt   = ema_dir_r;
    adc_nxt       = adc_r;
    soc_known_nxt = soc_known_r;
    cfull_nxt     = cfull_r;
    cnow_nxt      = cnow_r;
    soc_nxt       = soc_r;
    corr_neg_nxt  = corr_neg_r;
    mag_nxt       = mag_r;
    scale_ok_nxt  = scale_ok_r;
    ns_nxt        = ns_r;
    den_nxt       = den_r;
    x4_nxt        = x4_r;
    chg_nxt       = chg_r;
    nz_nxt        = nz_r;
    cur_ma_nxt    = cur_ma_r;
    curmag_nxt    = curmag_r;
    dir_nxt       = dir_r;
    rep_y_nxt     = rep_y_r;
    rep_sat_nxt   = rep_sat_r;
    chg_rep_nxt   = chg_rep_r;
    dsg_rep_nxt   = dsg_rep_r;
    capx_nxt      = capx_r;
    m_nxt         = m_r;
    p93_nxt       = p93_r;
    real_nxt      = real_r;
    tfull_nxt     = tfull_r;
    tempty_nxt    = tempty_r;
    out_data_nxt  = out_data_r;
    div_ctl.start = 1'b0;
    div_ctl.iters = ITER_X4;
    div_dividend  = scaled_c;
    div_divisor   = {4'd0, den_r};
    load_out      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          adc_nxt       = in_tdata[15:0];
          cfull_nxt     = in_tdata[31:16];
          cnow_nxt      = in_tdata[47:32];
          soc_nxt       = in_tdata[54:48];
          soc_known_nxt = in_tuser;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        corr_neg_nxt = corr_c[19];
        mag_nxt      = corr_abs[18:0];
        scale_ok_nxt = (corr_abs != 20'd0) && (res_sel != 16'd0) && (num_sel != 16'd0);
        ns_nxt       = 31'(num_sel) * 31'(NUM_SCALE);
        den_nxt      = 28'(res_sel) * 28'(DEN_SCALE);
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_sts.done) begin
          x4_nxt    = x4_c;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        nz_nxt      = (x4_r != 38'd0);
        chg_nxt     = (x4_r != 38'd0) && !corr_neg_r;
        curmag_nxt  = mag32_c;
        if (x4_r == 38'd0) begin
          cur_ma_nxt = 32'd0;
        end else if (!corr_neg_r) begin
          cur_ma_nxt = mag32_c;
        end else begin
          cur_ma_nxt = ~mag32_c + 32'd1;
        end
        if ((x4_r != 38'd0) && (mag32_c >= DIR_THRESH)) begin
          dir_nxt = corr_neg_r ? DIR_DSG : DIR_CHG;
        end else begin
          dir_nxt = DIR_IDLE;
        end
        rep_sat_nxt = (rep_sum >= REP_SAT);
        rep_y_nxt   = rep_sum[24:4];
        state_nxt   = ST_EMA;
      end
      ST_EMA: begin
        chg_rep_nxt = chg_r ? rep_c : 16'd0;
        dsg_rep_nxt = (nz_r && !chg_r) ? rep_c : 16'd0;
        capx_nxt    = 26'(cap_c) * 26'(MIN_FACTOR);
        if (dir_r == DIR_IDLE) begin
          ema_nxt     = 32'd0;
          ema_dir_nxt = DIR_IDLE;
        end else if ((dir_r != ema_dir_r) || (ema_r == 32'd0)) begin
          ema_nxt     = curmag_r;
          ema_dir_nxt = dir_r;
        end else begin
          ema_nxt = ema_sum[35:4];
        end
        state_nxt = ST_MIN;
      end
      ST_MIN: begin
        real_nxt   = UNKNOWN_MIN;
        tfull_nxt  = UNKNOWN_MIN;
        tempty_nxt = UNKNOWN_MIN;
        state_nxt  = ST_DONE;
        if (soc_known_r) begin
          if ((dir_r != DIR_IDLE) && (ema_r != 32'd0)) begin
            div_ctl.start = 1'b1;
            div_ctl.iters = ITER_MIN;
            div_dividend  = {capx_r, 23'd0};
            div_divisor   = ema_r;
            state_nxt     = ST_DIV2;
          end else if (soc_r == 7'd0) begin
            tempty_nxt = 16'd0;
          end else if (soc_r == SOC_FULL) begin
            tfull_nxt = 16'd0;
          end
        end
      end
      ST_DIV2: begin
        div_divisor = ema_r;
        if (div_sts.done) begin
          m_nxt     = (div_q[25:0] > 26'(MINUTES_CAP)) ? MINUTES_CAP : div_q[15:0];
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        p93_nxt   = 23'(m_r) * 23'(PCT_FACTOR);
        state_nxt = ST_PCT;
      end
      ST_PCT: begin
        real_nxt = m_r;
        if (dir_r == DIR_CHG) begin
          tfull_nxt  = pct_c;
          tempty_nxt = UNKNOWN_MIN;
        end else begin
          tfull_nxt  = UNKNOWN_MIN;
          tempty_nxt = pct_c;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {tempty_r, tfull_r, real_r, dsg_rep_r, chg_rep_r, cur_ma_r};
    end
  end

  // Register writes
  always_comb begin
    sense_res_value_nxt   = sense_res_value_r;
    sense_res_scale_nxt   = sense_res_scale_r;
    default_res_value_nxt = default_res_value_r;
    default_res_scale_nxt = default_res_scale_r;
    zero_offset_nxt       = zero_offset_r;
    zero_valid_nxt        = zero_valid_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SENSE_RES_VALUE:   sense_res_value_nxt   = cfg_data[15:0];
        CFG_SENSE_RES_SCALE:   sense_res_scale_nxt   = cfg_data[15:0];
        CFG_DEFAULT_RES_VALUE: default_res_value_nxt = cfg_data[15:0];
        CFG_DEFAULT_RES_SCALE: default_res_scale_nxt = cfg_data[15:0];
        CFG_ZERO_OFFSET_X4:    zero_offset_nxt       = cfg_data;
        CFG_ZERO_VALID:        zero_valid_nxt        = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control and config state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      out_valid_r         <= 1'b0;
      ema_r               <= 32'd0;
      ema_dir_r           <= DIR_IDLE;
      sense_res_value_r   <= 16'd0;
      sense_res_scale_r   <= 16'd0;
      default_res_value_r <= 16'd1;
      default_res_scale_r <= 16'd1;
      zero_offset_r       <= 19'd0;
      zero_valid_r        <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      out_valid_r         <= out_valid_nxt;
      ema_r               <= ema_nxt;
      ema_dir_r           <= ema_dir_nxt;
      sense_res_value_r   <= sense_res_value_nxt;
      sense_res_scale_r   <= sense_res_scale_nxt;
      default_res_value_r <= default_res_value_nxt;
      default_res_scale_r <= default_res_scale_nxt;
      zero_offset_r       <= zero_offset_nxt;
      zero_valid_r        <= zero_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    adc_r       <= adc_nxt;
    soc_known_r <= soc_known_nxt;
    cfull_r     <= cfull_nxt;
    cnow_r      <= cnow_nxt;
    soc_r       <= soc_nxt;
    corr_neg_r  <= corr_neg_nxt;
    mag_r       <= mag_nxt;
    scale_ok_r  <= scale_ok_nxt;
    ns_r        <= ns_nxt;
    den_r       <= den_nxt;
    x4_r        <= x4_nxt;
    chg_r       <= chg_nxt;
    nz_r        <= nz_nxt;
    cur_ma_r    <= cur_ma_nxt;
    curmag_r    <= curmag_nxt;
    dir_r       <= dir_nxt;
    rep_y_r     <= rep_y_nxt;
    rep_sat_r   <= rep_sat_nxt;
    chg_rep_r   <= chg_rep_nxt;
    dsg_rep_r   <= dsg_rep_nxt;
    capx_r      <= capx_nxt;
    m_r         <= m_nxt;
    p93_r       <= p93_nxt;
    real_r      <= real_nxt;
    tfull_r     <= tfull_nxt;
    tempty_r    <= tempty_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> !in_tready)
    else $error("divider busy while input ready");

  a_idle_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ema_dir_r == DIR_IDLE) |-> (ema_r == 32'd0))
    else $error("average nonzero with idle direction");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> ((state_r == ST_DIV1) || (state_r == ST_DIV2)))
    else $error("divider finished outside a wait step");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && !out_valid_r) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished word not loaded into output register");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for battery_current_and_eta_unit: drives ADC words over
// the input stream, scores every result word against a built-in predictor.
// Depends on bcet_pkg and the unit's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bcet_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 200;   // idle margin after the last result word
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 150;

  // scaling and estimate constants
  localparam longint K_X4       = 4;
  localparam longint K_NUM      = 20000;
  localparam longint K_DEN      = 2147;
  localparam longint K_DEADBAND = 2000;  // 500 mA in x4 units
  localparam longint K_REP_DIV  = 400;   // 100 mA in x4 units
  localparam longint K_THRESH   = 200;
  localparam longint K_MIN_MUL  = 600;
  localparam longint K_MIN_CAP  = 65534;
  localparam longint K_PCT      = 93;
  localparam longint K_PCT_DIV  = 100;
  localparam logic [15:0] K_UNKNOWN = 16'hFFFF;
  localparam logic [6:0]  K_SOC_FULL = 7'd100;

  typedef struct packed {
    logic [15:0] adc_word;
    logic        soc_known;
    logic [15:0] cap_full;
    logic [15:0] cap_now;
    logic [6:0]  soc_pct;
  } sample_t;

  // laid out like out_tdata, highest field first
  typedef struct packed {
    logic [15:0] min_empty;
    logic [15:0] min_full;
    logic [15:0] min_real;
    logic [15:0] dsg_rep;
    logic [15:0] chg_rep;
    logic [31:0] signed_ma;
  } report_t;

  typedef struct packed {
    logic [15:0] sense_res;
    logic [15:0] sense_scale;
    logic [15:0] dflt_res;
    logic [15:0] dflt_scale;
    logic [18:0] zero_x4;
    logic        zero_ok;
  } shunt_cfg_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [55:0]   in_tdata = '0;   // adc_word, capacity_full, capacity_now, soc_percent
  logic          in_tuser = 1'b0; // soc_known
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [111:0]  out_tdata;       // signed_ma, charge_report, discharge_report,
                                  // minutes_real, minutes_to_full, minutes_to_empty
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [18:0]   cfg_data = '0;

  battery_current_and_eta_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state: register copy and the direction-aware average
  shunt_cfg_t  cfg_now = '{16'd0, 16'd0, 16'd1, 16'd1, 19'd0, 1'b0};
  logic [31:0] avg_ma = '0;
  dir_t        avg_dir = DIR_IDLE;

  report_t     pending_reports[$];
  bit          tx_live = 1'b0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          rx_hold = 0;
  int unsigned rx_draw;
  int          quiet_cycles = 0;

  // random run shaping
  int run_left = 0;
  int run_base = 0;

  int n_sent = 0, n_checked = 0, n_writes = 0, n_mismatch = 0;
  int n_chg = 0, n_dsg = 0, n_idle = 0, n_sat = 0;

  // round x4 current to 100 mA units, saturating
  function automatic logic [15:0] hundred_ma_units(input logic [63:0] v_x4);
    logic [63:0] q;
    q = (v_x4 + K_REP_DIV / 2) / K_REP_DIV;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // expected result word for one sample; advances the average
  function automatic report_t predict_report(input sample_t s);
    logic [15:0] count_w;
    longint      corr, cur_ma;
    logic [63:0] mag, res, num, den, x4, ma, cur, cap, mins;
    dir_t        dir;
    report_t     r;
    count_w = {s.adc_word[7:0], s.adc_word[15:8]};
    corr = longint'($signed(count_w)) * K_X4;
    if (cfg_now.zero_ok) corr -= longint'($signed(cfg_now.zero_x4));
    mag = (corr < 0) ? 64'(-corr) : 64'(corr);
    res = (cfg_now.sense_res != 0) ? 64'(cfg_now.sense_res) : 64'(cfg_now.dflt_res);
    num = (cfg_now.sense_scale != 0) ? 64'(cfg_now.sense_scale) : 64'(cfg_now.dflt_scale);

    // scale to mA x4, then deadband without a learned zero
    x4 = '0;
    if (mag != 0 && res != 0 && num != 0) begin
      den = K_DEN * res;
      x4 = (mag * (K_NUM * num) + den / 2) / den;
    end
    if (!cfg_now.zero_ok && x4 < K_DEADBAND) x4 = '0;

    // signed mA with saturation
    ma = (x4 + K_X4 / 2) / K_X4;
    cur_ma = 0;
    if (x4 != 0) begin
      if (corr > 0) begin
        if (ma > 64'h7FFF_FFFF) n_sat++;
        cur_ma = (ma > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(ma);
      end else begin
        if (ma > 64'h8000_0000) n_sat++;
        cur_ma = (ma > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(ma);
      end
    end
    r.signed_ma = cur_ma[31:0];
    r.chg_rep = hundred_ma_units((cur_ma > 0) ? x4 : 64'd0);
    r.dsg_rep = hundred_ma_units((cur_ma < 0) ? x4 : 64'd0);

    // direction and 1/16 moving average
    cur = '0;
    if (cur_ma >= K_THRESH) begin
      dir = DIR_CHG;
      cur = 64'(cur_ma);
      n_chg++;
    end else if (cur_ma <= -K_THRESH) begin
      dir = DIR_DSG;
      cur = 64'(-cur_ma);
      n_dsg++;
    end else begin
      dir = DIR_IDLE;
      n_idle++;
    end
    if (dir == DIR_IDLE) begin
      avg_ma = '0;
      avg_dir = DIR_IDLE;
    end else if (dir != avg_dir || avg_ma == 0) begin
      avg_ma = cur[31:0];
      avg_dir = dir;
    end else begin
      avg_ma = 32'(({32'd0, avg_ma} * 15 + cur + 8) / 16);
    end

    // time estimates
    if (!s.soc_known) begin
      r.min_real = K_UNKNOWN;
      r.min_full = K_UNKNOWN;
      r.min_empty = K_UNKNOWN;
    end else if (dir != DIR_IDLE && avg_ma != 0) begin
      if (dir == DIR_CHG)
        cap = (s.cap_full >= s.cap_now) ? 64'(s.cap_full - s.cap_now) : 64'd0;
      else
        cap = 64'(s.cap_now);
      mins = cap * K_MIN_MUL / avg_ma;
      if (mins > K_MIN_CAP) mins = K_MIN_CAP;
      r.min_real = mins[15:0];
      mins = mins * K_PCT / K_PCT_DIV;
      r.min_full = (dir == DIR_CHG) ? mins[15:0] : K_UNKNOWN;
      r.min_empty = (dir == DIR_DSG) ? mins[15:0] : K_UNKNOWN;
    end else begin
      r.min_real = K_UNKNOWN;
      r.min_full = (s.soc_pct == K_SOC_FULL) ? 16'd0 : K_UNKNOWN;
      r.min_empty = (s.soc_pct == 7'd0) ? 16'd0 : K_UNKNOWN;
    end
    return r;
  endfunction

  // send one input word; valid stays up for a back-to-back follower
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      if (tx_live) begin
        in_tvalid <= 1'b0;
        tx_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {1'b0, s.soc_pct, s.cap_now, s.cap_full, s.adc_word};
    in_tuser <= s.soc_known;
    in_tvalid <= 1'b1;
    tx_live = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(predict_report(s));
    n_sent++;
  endtask

  // stop sending and wait for every expected result word
  task automatic wait_reports_drained();
    if (tx_live) begin
      in_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // write all six registers while idle; noisy puts junk above the field width
  task automatic load_config(input shunt_cfg_t c, input bit noisy);
    cfg_idx_t    idx;
    logic [18:0] data;
    wait_reports_drained();
    idx = idx.first();
    do begin
      case (idx)
        CFG_SENSE_RES_VALUE:   data = {noisy ? 3'($urandom) : 3'd0, c.sense_res};
        CFG_SENSE_RES_SCALE:   data = {noisy ? 3'($urandom) : 3'd0, c.sense_scale};
        CFG_DEFAULT_RES_VALUE: data = {noisy ? 3'($urandom) : 3'd0, c.dflt_res};
        CFG_DEFAULT_RES_SCALE: data = {noisy ? 3'($urandom) : 3'd0, c.dflt_scale};
        CFG_ZERO_OFFSET_X4:    data = c.zero_x4;
        default:               data = {noisy ? 18'($urandom) : 18'd0, c.zero_ok};
      endcase
      cfg_index <= idx;
      cfg_data <= data;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      n_writes++;
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  function automatic sample_t mk_sample(input int count, input bit known, input int full,
                                        input int now, input int soc);
    sample_t s;
    s.adc_word = {count[7:0], count[15:8]};
    s.soc_known = known;
    s.cap_full = 16'(full);
    s.cap_now = 16'(now);
    s.soc_pct = 7'(soc);
    return s;
  endfunction

  function automatic logic [15:0] pick_res_field();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return 19'h3FFFF;
      1:       return 19'h40000;
      2:       return 19'($urandom_range(0, 8000)) - 19'd4000;
      default: return 19'($urandom);
    endcase
  endfunction

  // mostly runs of similar current so the average settles, some raw noise
  function automatic sample_t make_sample();
    sample_t s;
    int      span, jit, cnt;
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      span = $urandom_range(0, 15);
      run_base = int'($urandom_range(0, (1 << span) - 1));
      if ($urandom_range(0, 1) == 1) run_base = -run_base;
    end
    run_left--;
    if ($urandom_range(0, 4) == 0) begin
      s.adc_word = 16'($urandom);
    end else begin
      jit = ((run_base < 0) ? -run_base : run_base) / 16 + 1;
      cnt = run_base + int'($urandom_range(0, 2 * jit)) - jit;
      if (cnt > 32767) cnt = 32767;
      if (cnt < -32768) cnt = -32768;
      s.adc_word = {cnt[7:0], cnt[15:8]};
    end
    s.soc_known = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0:       s.soc_pct = 7'd0;
      1:       s.soc_pct = K_SOC_FULL;
      2:       s.soc_pct = 7'($urandom_range(101, 127));
      default: s.soc_pct = 7'($urandom_range(0, 100));
    endcase
    s.cap_full = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
    s.cap_now = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, s.cap_full));
    return s;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endfunction

  // result receiver: random stalls per word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      rx_draw = rx_steady ? 0 : $urandom_range(0, 16);
      out_tready <= (rx_draw == 0);
      rx_hold <= rx_draw;
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold <= 0;
      out_tready <= 1'b1;
    end
  end

  // score each accepted result word against the oldest prediction
  always @(posedge clk) begin : score_results
    report_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = report_t'(out_tdata);
      if (pending_reports.size() == 0) begin
        $error("result word with no prediction waiting: %h", out_tdata);
        n_mismatch++;
      end else begin
        want = pending_reports.pop_front();
        check_field("signed_ma", 64'($signed(want.signed_ma)), 64'($signed(got.signed_ma)));
        check_field("charge_report", 64'(want.chg_rep), 64'(got.chg_rep));
        check_field("discharge_report", 64'(want.dsg_rep), 64'(got.dsg_rep));
        check_field("minutes_real", 64'(want.min_real), 64'(got.min_real));
        check_field("minutes_to_full", 64'(want.min_full), 64'(got.min_full));
        check_field("minutes_to_empty", 64'(want.min_empty), 64'(got.min_empty));
        n_checked++;
      end
    end
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles, %0d results outstanding",
             quiet_cycles, pending_reports.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset register values: idle SOC fallbacks, deadband, extremes of every field
  task automatic test_idle_and_soc();
    send_sample(mk_sample(0, 1'b1, 1000, 500, 0));
    send_sample(mk_sample(0, 1'b1, 1000, 500, 100));
    send_sample(mk_sample(0, 1'b1, 1000, 500, 50));
    send_sample(mk_sample(0, 1'b1, 1000, 500, 101));
    send_sample(mk_sample(0, 1'b1, 1000, 500, 127));
    send_sample(mk_sample(0, 1'b0, 1000, 500, 0));
    send_sample(mk_sample(50, 1'b1, 1000, 500, 40));      // inside the deadband
    send_sample(mk_sample(60, 1'b1, 1000, 2000, 40));     // remaining above full
    send_sample(mk_sample(-32768, 1'b1, 65535, 65535, 127));
    send_sample(mk_sample(32767, 1'b0, 65535, 0, 0));
    send_sample(mk_sample(-1, 1'b1, 65535, 65535, 127));
  endtask

  // valid zero: the +-200 mA threshold and the minutes cap
  task automatic test_threshold_and_eta_cap();
    load_config('{16'd0, 16'd0, 16'd1, 16'd1, 19'd0, 1'b1}, 1'b0);
    send_sample(mk_sample(21, 1'b1, 65535, 0, 50));
    send_sample(mk_sample(22, 1'b1, 65535, 0, 50));
    send_sample(mk_sample(22, 1'b1, 65535, 0, 50));
    send_sample(mk_sample(-22, 1'b1, 0, 65535, 50));
    send_sample(mk_sample(-21, 1'b1, 0, 65535, 50));
  endtask

  // huge scale: current saturates both ways, average runs on the clipped value
  task automatic test_saturation();
    load_config('{16'd1, 16'hFFFF, 16'd1, 16'd1, 19'd0, 1'b1}, 1'b0);
    send_sample(mk_sample(32767, 1'b1, 65535, 100, 50));
    send_sample(mk_sample(32767, 1'b1, 65535, 100, 50));
    send_sample(mk_sample(-32768, 1'b1, 65535, 65535, 50));
    send_sample(mk_sample(1, 1'b1, 65535, 100, 50));
  endtask

  // zero resistance or zero scale after the default fallback
  task automatic test_zero_resistance();
    load_config('{16'd0, 16'd0, 16'd0, 16'd5, 19'd0, 1'b1}, 1'b0);
    send_sample(mk_sample(1000, 1'b1, 2000, 1000, 0));
    send_sample(mk_sample(-1000, 1'b1, 2000, 1000, 100));
    load_config('{16'd7, 16'd0, 16'd3, 16'd0, 19'd0, 1'b1}, 1'b0);
    send_sample(mk_sample(1000, 1'b1, 2000, 1000, 50));
  endtask

  // offset at both ends of its range flips the sign of the corrected count
  task automatic test_offset_extremes();
    load_config('{16'd0, 16'd0, 16'd1, 16'd1, 19'h3FFFF, 1'b1}, 1'b0);
    send_sample(mk_sample(0, 1'b1, 3000, 1500, 50));
    send_sample(mk_sample(32767, 1'b1, 3000, 1500, 50));
    load_config('{16'd0, 16'd0, 16'd1, 16'd1, 19'h40000, 1'b1}, 1'b0);
    send_sample(mk_sample(0, 1'b1, 3000, 1500, 50));
    send_sample(mk_sample(-32768, 1'b1, 3000, 1500, 50));
  endtask

  // phases of random traffic, each under its own register setting and idling mix
  task automatic test_random_traffic();
    shunt_cfg_t c;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = '{16'd0, 16'd0, 16'd1, 16'd1, 19'd0, 1'b0};
        1: c = '{16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)), pick_res_field(),
                 pick_res_field(), 19'($urandom_range(0, 800)) - 19'd400, 1'b1};
        2: c = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 19'h3FFFF, 1'b1};
        3: c = '{16'd0, 16'd0, 16'd0, 16'd0, 19'h40000, 1'b0};
        4: c = '{16'd1, 16'hFFFF, pick_res_field(), pick_res_field(), pick_offset(),
                 1'($urandom)};
        default: c = '{pick_res_field(), pick_res_field(), pick_res_field(), pick_res_field(),
                       pick_offset(), 1'($urandom)};
      endcase
      load_config(c, ph >= 5);
      tx_steady = ph[0];
      rx_steady = ph[1];
      run_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 49) == 0) wait_reports_drained();
        send_sample(make_sample());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_soc();
    test_threshold_and_eta_cap();
    test_saturation();
    test_zero_resistance();
    test_offset_extremes();
    test_random_traffic();
    wait_reports_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d words (%0d charging, %0d discharging, %0d idle, %0d saturated)",
             n_sent, n_chg, n_dsg, n_idle, n_sat);
    $display("with %0d register writes; %0d results scored, %0d mismatches.",
             n_writes, n_checked, n_mismatch);
    if (n_mismatch == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bcet_pkg.sv
rtl/bcet_div.sv
rtl/battery_current_and_eta_unit.sv
tb/tb_top.sv
